// ===== rtl/pcxrle_pkg.sv =====
// Shared types, constants and byte functions for the PCX-style RLE line encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package pcxrle_pkg;

   localparam logic [5:0] RUN_MAX    = 6'h3f;
   localparam logic [7:0] COUNT_MARK = 8'hc0;
   localparam int         QueueDepth = 4;

   // One queued command: the run closed by a differing byte or at RUN_MAX, and the line-end flush
   typedef struct packed {
      logic       ended_valid;
      logic [7:0] ended_value;
      logic [5:0] ended_len;
      logic       flush_valid;
      logic [7:0] flush_value;
      logic [5:0] flush_len;
   } run_cmd_type;

   // Reverse bit order, then invert every bit
   function automatic logic [7:0] flip_invert(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = ~b[i];
      end
      return r;
   endfunction

   // A count marker precedes the data byte for long runs or when the data byte looks like a marker
   function automatic logic need_count(input logic [5:0] len, input logic [7:0] value);
      logic [7:0] d;
      d = flip_invert(value);
      return (len > 6'd1) || (d[7:6] == 2'b11);
   endfunction

   function automatic logic [7:0] count_byte(input logic [5:0] len);
      return COUNT_MARK | {2'b00, len};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pcxrle_front.sv =====
// Front end of the PCX-style RLE line encoder: accepts raw bytes, tracks the open run
// and pushes a command to the queue whenever a run closes. Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [7:0]              req_tdata,   // [7:0] pixel_byte
   input  wire                     req_tlast,   // line_last
   input  wire                     q_full,
   output logic                    q_push,
   output pcxrle_pkg::run_cmd_type q_cmd
);

   logic [7:0] run_value_ff, run_value_in;
   logic [5:0] run_length_ff, run_length_in;
   logic       run_open_ff, run_open_in;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      logic [7:0] nxt_value;
      logic [5:0] nxt_len;
      q_cmd             = '0;
      q_cmd.ended_value = run_value_ff;
      q_cmd.ended_len   = run_length_ff;
      nxt_value         = req_tdata;
      nxt_len           = 6'd1;
      if (!run_open_ff) begin
         nxt_value = req_tdata;
         nxt_len   = 6'd1;
      end else if (req_tdata == run_value_ff && run_length_ff != pcxrle_pkg::RUN_MAX) begin
         nxt_value = run_value_ff;
         nxt_len   = run_length_ff + 6'd1;
      end else begin
         q_cmd.ended_valid = 1'b1;
      end
      q_cmd.flush_value = nxt_value;
      q_cmd.flush_len   = nxt_len;
      q_cmd.flush_valid = req_tlast;
      // line end flushes the run and closes it
      if (req_tlast) begin
         run_value_in  = 8'd0;
         run_length_in = 6'd0;
         run_open_in   = 1'b0;
      end else begin
         run_value_in  = nxt_value;
         run_length_in = nxt_len;
         run_open_in   = 1'b1;
      end
   end

   assign q_push = accept && (q_cmd.ended_valid || q_cmd.flush_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 8'd0;
         run_length_ff <= 6'd0;
         run_open_ff   <= 1'b0;
      end else if (accept) begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
         run_open_ff   <= run_open_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pcxrle_queue.sv =====
// Small command FIFO between front and back of the PCX-style RLE line encoder.
// Register array with head read; depends on pcxrle_pkg.
`default_nettype none

module pcxrle_queue #(
   parameter int DEPTH = pcxrle_pkg::QueueDepth
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  pcxrle_pkg::run_cmd_type push_cmd,
   output logic                    full,
   input  wire                     pop,
   output logic                    head_valid,
   output pcxrle_pkg::run_cmd_type head_cmd
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   pcxrle_pkg::run_cmd_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pcxrle_back.sv =====
// Back end of the PCX-style RLE line encoder: expands each queued command into count
// and data bytes, one per cycle unless stalled, via a registered output. Needs pcxrle_pkg.
`default_nettype none

module pcxrle_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     head_valid,
   input  pcxrle_pkg::run_cmd_type head_cmd,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] code_byte
   output logic [1:0]              rsp_tuser,   // [0] is_count, [1] item_last
   output logic                    rsp_tlast    // line_end
);

   // slot bits: [0] closed-run count, [1] closed-run data, [2] flush count, [3] flush data
   pcxrle_pkg::run_cmd_type cur_ff;
   logic [3:0] pend_ff, pend_in;
   logic       cur_valid_ff, cur_valid_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;
   logic       rsp_last_ff;

   logic [3:0] sel;
   logic [3:0] remaining;
   logic [7:0] code;
   logic       is_count;
   logic       line_end;
   logic       out_ready;
   logic       emit;
   logic [3:0] load_mask;

   always_comb begin
      sel      = 4'b0000;
      code     = pcxrle_pkg::flip_invert(cur_ff.flush_value);
      is_count = 1'b0;
      line_end = 1'b0;
      if (pend_ff[0]) begin
         sel      = 4'b0001;
         code     = pcxrle_pkg::count_byte(cur_ff.ended_len);
         is_count = 1'b1;
      end else if (pend_ff[1]) begin
         sel  = 4'b0010;
         code = pcxrle_pkg::flip_invert(cur_ff.ended_value);
      end else if (pend_ff[2]) begin
         sel      = 4'b0100;
         code     = pcxrle_pkg::count_byte(cur_ff.flush_len);
         is_count = 1'b1;
      end else if (pend_ff[3]) begin
         sel      = 4'b1000;
         line_end = 1'b1;
      end
   end

   assign remaining = pend_ff & ~sel;
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign emit      = cur_valid_ff && out_ready;
   assign pop       = head_valid && (!cur_valid_ff || (emit && remaining == 4'b0000));

   assign load_mask = {head_cmd.flush_valid,
                       head_cmd.flush_valid &&
                          pcxrle_pkg::need_count(head_cmd.flush_len, head_cmd.flush_value),
                       head_cmd.ended_valid,
                       head_cmd.ended_valid &&
                          pcxrle_pkg::need_count(head_cmd.ended_len, head_cmd.ended_value)};

   always_comb begin
      pend_in      = pend_ff;
      cur_valid_in = cur_valid_ff;
      if (pop) begin
         pend_in      = load_mask;
         cur_valid_in = 1'b1;
      end else if (emit) begin
         pend_in      = remaining;
         cur_valid_in = (remaining != 4'b0000);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 4'b0000;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         cur_valid_ff <= cur_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd;
      end
      if (emit) begin
         rsp_data_ff <= code;
         rsp_user_ff <= {remaining == 4'b0000, is_count};
         rsp_last_ff <= line_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/pcx_rle_line_encoder_unit.sv =====
// A run-closing byte goes through the queue, cur_ff and the output register to rsp_tvalid.
// Throughput: one input byte per cycle while the queue has room; one code byte per cycle out
// while rsp_tready allows, so an input that closes a run and needs a count marker costs two
// output bytes, up to four at line end; the back end's single output register sets the rate.
// Reset: synchronous, active high; clears the open run, the command queue and the output stage.
`default_nettype none

module pcx_rle_line_encoder_unit #(
   parameter int QUEUE_DEPTH = pcxrle_pkg::QueueDepth
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] pixel_byte
   input  wire        req_tlast,   // line_last
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] code_byte
   output logic [1:0] rsp_tuser,   // [0] is_count, [1] item_last
   output logic       rsp_tlast    // line_end
);

   logic                    q_push;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_valid;
   pcxrle_pkg::run_cmd_type q_in_cmd;
   pcxrle_pkg::run_cmd_type q_head_cmd;

   pcxrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd)
   );

   pcxrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_in_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   pcxrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from an empty queue");

   a_count_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (!rsp_tuser[1] && !rsp_tlast))
      else $error("count marker closes a transaction group");

   a_count_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[7:6] == 2'b11 && rsp_tdata[5:0] != 6'd0))
      else $error("malformed count marker");

endmodule

`default_nettype wire
